/* hdl/tmwf_pkg.sv */
// Shared types and constants for the trimmed-mean window filter.
// No dependencies.
`timescale 1ns / 1ps

package tmwf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SIZE_W   = 6;
    localparam int SIZE_RST = 8;
    localparam int SIZE_MIN = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_TRIM,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

/* hdl/trimmed_mean_window_filter.sv */
// Trimmed moving-average filter: circular sample window in RAM, scan, sequential divide.
// A filling item only writes the window RAM; a result item is scanned, trimmed and then
// divided. One item is processed at a time: a new sample is taken only in the idle
// state, after the previous result has been loaded for output. The scan reads one RAM
// entry per cycle.
// Synchronous active-low reset sets window_size to 8 and empties the window; a
// window_size write empties it the same way. No clearing pass is needed.
// Depends on tmwf_pkg, tmwf_ram, tmwf_div.
`timescale 1ns / 1ps

module trimmed_mean_window_filter #(
    parameter int MAX_WINDOW = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tmwf_pkg::SIZE_W-1:0]         cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [tmwf_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tmwf_pkg::SAMPLE_W-1:0] m_filtered
);

    localparam int SAMPLE_W = tmwf_pkg::SAMPLE_W;
    localparam int SIZE_W   = tmwf_pkg::SIZE_W;
    localparam int PTR_W    = $clog2(MAX_WINDOW);
    localparam int CNT_W    = (PTR_W + 1 > SIZE_W) ? PTR_W + 1 : SIZE_W;
    localparam int SUM_W    = SAMPLE_W + PTR_W + 1;
    localparam int SIZE_RST = (MAX_WINDOW < tmwf_pkg::SIZE_RST) ? MAX_WINDOW
                                                                : tmwf_pkg::SIZE_RST;

    tmwf_pkg::state_t state_reg, state_next;

    logic [SIZE_W-1:0]          size_reg;
    logic [SIZE_W-1:0]          fill_reg;
    logic [PTR_W-1:0]           wptr_reg;
    logic [PTR_W-1:0]           scan_reg;
    logic                       rd_valid_reg;
    logic                       rd_first_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SAMPLE_W-1:0] lo_reg;
    logic signed [SAMPLE_W-1:0] hi_reg;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_filtered_reg;

    logic                       s_accept;
    logic                       cfg_accept;
    logic                       fill_done;
    logic                       scan_last;
    logic                       wptr_wrap;
    logic [SIZE_W-1:0]          size_clamped;
    logic                       ram_re;
    logic                       div_start;
    logic                       out_load;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SAMPLE_W-1:0] rd_sample;
    logic signed [SUM_W-1:0]    trimmed;
    logic                       div_done;
    logic signed [SAMPLE_W-1:0] div_quotient;

    assign cfg_ready  = (state_reg == tmwf_pkg::ST_IDLE);
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_accept   = s_valid && s_ready;
    assign fill_done  = !(fill_reg < size_reg);
    assign scan_last  = CNT_W'(scan_reg) == CNT_W'(size_reg) - CNT_W'(1);
    assign wptr_wrap  = CNT_W'(wptr_reg) == CNT_W'(size_reg) - CNT_W'(1);
    assign rd_sample  = $signed(ram_rdata);
    assign trimmed    = sum_reg - SUM_W'(lo_reg) - SUM_W'(hi_reg);

    always_comb begin
        if (int'(cfg_data) < tmwf_pkg::SIZE_MIN) begin
            size_clamped = SIZE_W'(tmwf_pkg::SIZE_MIN);
        end else if (int'(cfg_data) > MAX_WINDOW) begin
            size_clamped = SIZE_W'(MAX_WINDOW);
        end else begin
            size_clamped = cfg_data;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tmwf_pkg::ST_IDLE: begin
                if (s_accept && fill_done) begin
                    state_next = tmwf_pkg::ST_SCAN;
                end
            end
            tmwf_pkg::ST_SCAN: begin
                if (scan_last) begin
                    state_next = tmwf_pkg::ST_LAST;
                end
            end
            tmwf_pkg::ST_LAST: state_next = tmwf_pkg::ST_TRIM;
            tmwf_pkg::ST_TRIM: state_next = tmwf_pkg::ST_DIV;
            tmwf_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = tmwf_pkg::ST_OUT;
                end
            end
            tmwf_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = tmwf_pkg::ST_IDLE;
                end
            end
            default: state_next = tmwf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        ram_re    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            tmwf_pkg::ST_IDLE: s_ready   = !cfg_valid;
            tmwf_pkg::ST_SCAN: ram_re    = 1'b1;
            tmwf_pkg::ST_TRIM: div_start = 1'b1;
            tmwf_pkg::ST_OUT:  out_load  = !m_valid_reg || m_ready;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tmwf_pkg::ST_IDLE;
            size_reg     <= SIZE_W'(SIZE_RST);
            fill_reg     <= '0;
            wptr_reg     <= '0;
            scan_reg     <= '0;
            rd_valid_reg <= 1'b0;
            rd_first_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= ram_re;
            if (cfg_accept) begin
                size_reg <= size_clamped;
                fill_reg <= '0;
                wptr_reg <= '0;
            end else if (s_accept) begin
                wptr_reg <= wptr_wrap ? '0 : wptr_reg + PTR_W'(1);
                if (!fill_done) begin
                    fill_reg <= fill_reg + SIZE_W'(1);
                end
            end
            if (s_accept) begin
                scan_reg     <= '0;
                rd_first_reg <= 1'b1;
            end else if (ram_re) begin
                scan_reg <= scan_reg + PTR_W'(1);
            end
            if (rd_valid_reg) begin
                rd_first_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_valid_reg) begin
            if (rd_first_reg) begin
                sum_reg <= SUM_W'(rd_sample);
                lo_reg  <= rd_sample;
                hi_reg  <= rd_sample;
            end else begin
                sum_reg <= sum_reg + SUM_W'(rd_sample);
                if (rd_sample < lo_reg) begin
                    lo_reg <= rd_sample;
                end
                if (rd_sample > hi_reg) begin
                    hi_reg <= rd_sample;
                end
            end
        end
        if (out_load) begin
            m_filtered_reg <= div_quotient;
        end
    end

    tmwf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_window (
        .aclk  (aclk),
        .we    (s_accept),
        .waddr (wptr_reg),
        .wdata (s_sample),
        .re    (ram_re),
        .raddr (scan_reg),
        .rdata (ram_rdata)
    );

    tmwf_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (SIZE_W),
        .QUOTIENT_W (SAMPLE_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (trimmed),
        .divisor  (size_reg - SIZE_W'(2)),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;

endmodule

/* hdl/tmwf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module tmwf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/tmwf_div.sv */
// Sequential signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero.
// Depends on tmwf_pkg for default widths.
`timescale 1ns / 1ps

module tmwf_div #(
    parameter int DIVIDEND_W = 22,
    parameter int DIVISOR_W  = tmwf_pkg::SIZE_W,
    parameter int QUOTIENT_W = tmwf_pkg::SAMPLE_W
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]         divisor,
    output logic                         done,
    output logic signed [QUOTIENT_W-1:0] quotient
);

    localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  neg_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  fits;
    logic [DIVIDEND_W-1:0] magnitude;
    logic [DIVIDEND_W-1:0] quo_signed;

    assign magnitude  = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
    assign rem_shift  = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign rem_diff   = rem_shift - {1'b0, divisor_reg};
    assign fits       = rem_shift >= {1'b0, divisor_reg};
    assign quo_signed = neg_reg ? DIVIDEND_W'(-quo_reg) : quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIVIDEND_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg     <= dividend[DIVIDEND_W-1];
            divisor_reg <= divisor;
            rem_reg     <= '0;
            quo_reg     <= magnitude;
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = $signed(quo_signed[QUOTIENT_W-1:0]);

endmodule

/* verif/tb.sv */
// Self-checking testbench for trimmed_mean_window_filter: a scoreboard class predicts the
// trimmed mean for each result item, and plain tasks drive samples and window sizes.
// Depends on tmwf_pkg and the trimmed_mean_window_filter RTL.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_WIN     = 32;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE      = 100;
    localparam int RAND_ITEMS  = 1850;

    typedef logic signed [tmwf_pkg::SAMPLE_W-1:0] sample_t;

    class window_scoreboard;
        sample_t     win [MAX_WIN];
        int unsigned wr_ptr;
        int unsigned filled;
        int unsigned win_len;
        sample_t     expected_means [$];
        int          errors;
        int          results_seen;
        int          flat_windows;

        function new();
            win_len = tmwf_pkg::SIZE_RST;
            clear();
        endfunction

        function void clear();
            foreach (win[i]) win[i] = '0;
            wr_ptr = 0;
            filled = 0;
        endfunction

        function void set_size(logic [tmwf_pkg::SIZE_W-1:0] v);
            if (v < tmwf_pkg::SIZE_MIN) win_len = tmwf_pkg::SIZE_MIN;
            else if (v > MAX_WIN) win_len = MAX_WIN;
            else win_len = v;
            clear();
        endfunction

        function void note_sample(sample_t s);
            int total;
            int lo;
            int hi;
            int q;
            win[wr_ptr] = s;
            wr_ptr = (wr_ptr + 1) % win_len;
            if (filled < win_len) begin
                filled++;
                return;
            end
            lo = win[0];
            hi = win[0];
            total = 0;
            for (int i = 0; i < win_len; i++) begin
                if (win[i] < lo) lo = win[i];
                if (win[i] > hi) hi = win[i];
                total += win[i];
            end
            if (lo == hi) flat_windows++;
            total -= lo + hi;
            q = total / (int'(win_len) - 2);
            expected_means.push_back(q[tmwf_pkg::SAMPLE_W-1:0]);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30) $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(sample_t got);
            sample_t want;
            results_seen++;
            if (expected_means.size() == 0) begin
                report($sformatf("unexpected item, filtered=%0d", got));
                return;
            end
            want = expected_means.pop_front();
            if (got !== want)
                report($sformatf("filtered=%0d, expected %0d", got, want));
        endtask
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [tmwf_pkg::SIZE_W-1:0]     cfg_data = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    sample_t                         s_sample = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    sample_t                         m_filtered;

    window_scoreboard board = new();
    bit  calm     = 1'b0;
    bit  hold_req = 1'b0;
    int  samples_in;
    int  size_writes;
    int  holds_done;

    trimmed_mean_window_filter #(.MAX_WINDOW(MAX_WIN)) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                board.set_size(cfg_data);
                size_writes++;
            end
            if (s_valid && s_ready) begin
                board.note_sample(s_sample);
                samples_in++;
            end
            if (m_valid && m_ready) board.check_result(m_filtered);
        end
    end

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    function automatic int sender_gap();
        if (calm) return 0;
        if ($urandom_range(0, 99) < 55) return 0;
        return stall_len();
    endfunction

    function automatic sample_t next_sample(sample_t prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return sample_t'($urandom_range(0, 65535));
        if (r < 70) return prev + sample_t'($urandom_range(0, 64)) - sample_t'(32);
        if (r < 80) begin
            case ($urandom_range(0, 3))
                0: return 16'sh8000;
                1: return 16'sh7fff;
                2: return '0;
                default: return '1;
            endcase
        end
        return prev;
    endfunction

    // receiver: random ready, calm stretches, and one long hold-off on request
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                holds_done++;
            end else if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
                m_ready <= 1'b0;
                repeat (stall_len()) @(posedge aclk);
            end
        end
    end

    task automatic send_sample(input sample_t v);
        int gap;
        s_valid  <= 1'b1;
        s_sample <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        gap = sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // block idle: every result in, then room for a trailing filling item
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.expected_means.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_size(input logic [tmwf_pkg::SIZE_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_phase(input int items, input bit with_hold);
        sample_t prev;
        sample_t flat;
        int      sent;
        int      run;
        bit      held;
        prev = '0;
        sent = 0;
        held = 1'b0;
        while (sent < items) begin
            if (with_hold && !held && sent >= 5) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if ($urandom_range(0, 11) == 0) begin
                // constant stretch, long enough to flatten the window
                flat = ($urandom_range(0, 3) == 0) ? 16'sh8000 :
                       sample_t'($urandom_range(0, 65535));
                run  = board.win_len + $urandom_range(0, 3);
                repeat (run) send_sample(flat);
                sent += run;
                prev = flat;
            end else begin
                prev = next_sample(prev);
                send_sample(prev);
                sent++;
            end
        end
    endtask

    initial begin
        sample_t                     reset_set [10];
        sample_t                     min_set [12];
        logic [tmwf_pkg::SIZE_W-1:0] sizes [10];
        logic [tmwf_pkg::SIZE_W-1:0] sz;
        int                          total;
        int                          phase;
        int                          waited;

        reset_set = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
                      16'sh5555, 16'shaaaa, 16'sh7ffe, 16'sh8001, 16'sh1234};
        min_set   = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000,
                      16'sh8000, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
                      16'sh7fff, 16'sh8000};
        sizes     = '{6'd63, 6'd32, 6'd1, 6'd2, 6'd33, 6'd3, 6'd8, 6'd40, 6'd31, 6'd4};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset window length, then a write below the minimum
        foreach (reset_set[i]) send_sample(reset_set[i]);
        write_size(6'd0);
        foreach (min_set[i]) send_sample(min_set[i]);

        total = 0;
        phase = 0;
        while (total < RAND_ITEMS) begin
            sz = (phase < 10) ? sizes[phase] : 6'($urandom_range(0, 63));
            write_size(sz);
            calm = ($urandom_range(0, 3) == 0);
            run_phase(board.win_len + $urandom_range(20, 90), phase == 2 || phase == 9);
            total += samples_in - total - 22;
            total = samples_in - 22;
            phase++;
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        waited = 0;
        while (board.expected_means.size() != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE) @(posedge aclk);
        while (board.expected_means.size() != 0) begin
            board.report($sformatf("missing item, expected %0d",
                                   board.expected_means.pop_front()));
        end

        $display("covered %0d samples, %0d results (%0d flat windows), %0d window writes",
                 samples_in, board.results_seen, board.flat_windows, size_writes);
        $display("window lengths 3..32 incl. clamped writes, %0d long output hold-offs",
                 holds_done);
        if (board.errors == 0) begin
            $display("trimmed_mean_window_filter regression: pass");
        end else begin
            $display("trimmed_mean_window_filter regression: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("trimmed_mean_window_filter regression: fail");
        $finish;
    end

endmodule
